### rtl/hmfq_pkg.sv
// Package for the HID message framer queue: constants, types and helper functions.
`default_nettype none
package hmfq_pkg;

  localparam int QUEUE_FRAMES = 128;
  localparam int FRAME_BYTES  = 64;
  localparam int INIT_PAYLOAD = 57;
  localparam int CONT_PAYLOAD = 59;

  localparam int INIT_HDR = 7;
  localparam int CONT_HDR = 5;
  localparam int INIT_EFF = (INIT_PAYLOAD < FRAME_BYTES - INIT_HDR) ?
                            INIT_PAYLOAD : (FRAME_BYTES - INIT_HDR);
  localparam int CONT_EFF = (CONT_PAYLOAD < FRAME_BYTES - CONT_HDR) ?
                            CONT_PAYLOAD : (FRAME_BYTES - CONT_HDR);
  localparam int INIT_LIMIT = INIT_HDR + INIT_EFF;
  localparam int CONT_LIMIT = CONT_HDR + CONT_EFF;

  localparam int SLOT_W = $clog2(QUEUE_FRAMES);
  localparam int IDX_W  = $clog2(FRAME_BYTES);
  localparam int FILL_W = $clog2(FRAME_BYTES + 1);
  localparam int ADDR_W = $clog2(QUEUE_FRAMES * FRAME_BYTES);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_DATA  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [7:0]  cmd;
    logic [31:0] channel_id;
    logic [15:0] msg_length;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
    logic       empty_res;
  } rsp_t;

  // per-slot header and fill, kept apart from the payload bytes
  typedef struct packed {
    logic [31:0] chan;
    logic [7:0]  tag;
    logic [15:0] len;
    logic        init;
    fill_t       fill;
  } meta_t;

  typedef struct packed {
    logic       en;
    addr_t      addr;
    logic [7:0] data;
  } data_wr_t;

  typedef struct packed {
    logic  en;
    slot_t slot;
    meta_t meta;
  } meta_wr_t;

  typedef struct packed {
    logic  meta_en;
    slot_t meta_slot;
    logic  data_en;
    addr_t data_addr;
  } rd_req_t;

  function automatic slot_t next_slot(slot_t s);
    return (s == slot_t'(QUEUE_FRAMES - 1)) ? '0 : slot_t'(s + slot_t'(1));
  endfunction

  function automatic addr_t byte_addr(slot_t s, idx_t i);
    return addr_t'(addr_t'(s) * addr_t'(FRAME_BYTES)) + addr_t'(i);
  endfunction

endpackage
`default_nettype wire

### rtl/hmfq_store.sv
// Frame payload memory and per-slot header memory, both with registered reads.
`default_nettype none
module hmfq_store (
  input  wire logic              clk,
  input  wire hmfq_pkg::data_wr_t data_wr,
  input  wire hmfq_pkg::meta_wr_t meta_wr,
  input  wire hmfq_pkg::rd_req_t  rd,
  output logic [7:0]             data_rdata,
  output hmfq_pkg::meta_t        meta_rdata
);

  logic [7:0]      data_mem [hmfq_pkg::QUEUE_FRAMES * hmfq_pkg::FRAME_BYTES];
  hmfq_pkg::meta_t meta_mem [hmfq_pkg::QUEUE_FRAMES];

  always_ff @(posedge clk) begin
    if (data_wr.en) begin
      data_mem[data_wr.addr] <= data_wr.data;
    end
    if (rd.data_en) begin
      data_rdata <= data_mem[rd.data_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (meta_wr.en) begin
      meta_mem[meta_wr.slot] <= meta_wr.meta;
    end
    if (rd.meta_en) begin
      meta_rdata <= meta_mem[rd.meta_slot];
    end
  end

endmodule
`default_nettype wire

### rtl/hmfq_builder.sv
// Frame builder: message state, payload byte writes and frame commit to the ring.
`default_nettype none
module hmfq_builder (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               do_begin,
  input  wire logic               do_data,
  input  wire hmfq_pkg::req_t     req,
  input  wire hmfq_pkg::slot_t    head,
  output hmfq_pkg::slot_t         tail,
  output hmfq_pkg::data_wr_t      data_wr,
  output hmfq_pkg::meta_wr_t      meta_wr
);

  logic                 message_active;
  logic [15:0]          bytes_remaining;
  hmfq_pkg::idx_t       frame_fill;
  logic [7:0]           sequence_count;
  logic [31:0]          saved_channel;
  logic [7:0]           tag;
  logic [15:0]          saved_len;
  logic                 in_init;

  logic                 data_ok;
  logic                 open_cont;
  hmfq_pkg::idx_t       fill_eff;
  logic [7:0]           tag_eff;
  logic                 init_eff;
  logic [15:0]          rem_dec;
  hmfq_pkg::fill_t      fill_inc;
  hmfq_pkg::fill_t      limit;
  logic                 commit;
  hmfq_pkg::slot_t      tail_next;

  always_comb begin
    data_ok   = do_data && message_active;
    open_cont = frame_fill == '0;
    fill_eff  = open_cont ? hmfq_pkg::idx_t'(hmfq_pkg::CONT_HDR) : frame_fill;
    tag_eff   = open_cont ? sequence_count : tag;
    init_eff  = open_cont ? 1'b0 : in_init;
    rem_dec   = bytes_remaining - 16'd1;
    fill_inc  = hmfq_pkg::fill_t'(fill_eff) + hmfq_pkg::fill_t'(1);
    limit     = init_eff ? hmfq_pkg::fill_t'(hmfq_pkg::INIT_LIMIT)
                         : hmfq_pkg::fill_t'(hmfq_pkg::CONT_LIMIT);
    tail_next = hmfq_pkg::next_slot(tail);

    data_wr.en   = data_ok;
    data_wr.addr = hmfq_pkg::byte_addr(tail, fill_eff);
    data_wr.data = req.data_byte;

    meta_wr.slot = tail;
    if (do_begin) begin
      commit = req.msg_length == 16'd0;
      meta_wr.meta.chan = req.channel_id;
      meta_wr.meta.tag  = req.cmd;
      meta_wr.meta.len  = req.msg_length;
      meta_wr.meta.init = 1'b1;
      meta_wr.meta.fill = hmfq_pkg::fill_t'(hmfq_pkg::INIT_HDR);
    end else begin
      commit = data_ok && ((rem_dec == 16'd0) || (fill_inc >= limit));
      meta_wr.meta.chan = saved_channel;
      meta_wr.meta.tag  = tag_eff;
      meta_wr.meta.len  = saved_len;
      meta_wr.meta.init = init_eff;
      meta_wr.meta.fill = fill_inc;
    end
    // a full ring drops the frame: the slot is simply reused
    meta_wr.en = commit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail            <= '0;
      message_active  <= 1'b0;
      bytes_remaining <= '0;
      frame_fill      <= '0;
      sequence_count  <= '0;
      saved_channel   <= '0;
      tag             <= '0;
      saved_len       <= '0;
      in_init         <= 1'b0;
    end else begin
      if (commit && (tail_next != head)) begin
        tail <= tail_next;
      end
      if (do_begin) begin
        saved_channel   <= req.channel_id;
        sequence_count  <= '0;
        tag             <= req.cmd;
        saved_len       <= req.msg_length;
        in_init         <= 1'b1;
        bytes_remaining <= req.msg_length;
        message_active  <= req.msg_length != 16'd0;
        frame_fill      <= (req.msg_length == 16'd0) ? '0
                           : hmfq_pkg::idx_t'(hmfq_pkg::INIT_HDR);
      end else if (data_ok) begin
        if (open_cont) begin
          sequence_count <= sequence_count + 8'd1;
          tag            <= sequence_count;
          in_init        <= 1'b0;
        end
        bytes_remaining <= rem_dec;
        frame_fill      <= commit ? '0 : fill_inc[hmfq_pkg::IDX_W-1:0];
        if (rem_dec == 16'd0) begin
          message_active <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/hmfq_reader.sv
// Read sequencer: pops the head frame byte by byte through a two-entry output buffer.
`default_nettype none
module hmfq_reader (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             do_read,
  input  wire logic             do_clear,
  input  wire hmfq_pkg::slot_t  tail,
  input  wire hmfq_pkg::meta_t  meta_rdata,
  input  wire logic [7:0]       data_rdata,
  input  wire logic             rsp_ready,
  output logic                  busy,
  output hmfq_pkg::slot_t       head,
  output hmfq_pkg::rd_req_t     rd,
  output logic                  rsp_valid,
  output hmfq_pkg::rsp_t        rsp
);

  typedef enum logic [3:0] {
    RS_IDLE  = 4'b0001,
    RS_META  = 4'b0010,
    RS_BYTES = 4'b0100,
    RS_EMPTY = 4'b1000
  } rd_state_t;

  rd_state_t        state;
  hmfq_pkg::slot_t  rd_slot;
  hmfq_pkg::meta_t  meta;
  hmfq_pkg::idx_t   idx;

  // issue stage: byte in flight from memory or a header value
  logic             st_valid;
  logic             st_mem;
  logic [7:0]       st_byte;
  logic             st_last;
  logic             st_empty;

  logic             skid_valid;
  hmfq_pkg::rsp_t   skid;

  logic             pop;
  logic [1:0]       occ;
  logic             space;
  logic             issue;
  logic             sel_mem;
  logic [7:0]       sel_byte;
  hmfq_pkg::rsp_t   incoming;

  always_comb begin
    pop   = rsp_valid && rsp_ready;
    occ   = 2'(rsp_valid) + 2'(skid_valid) + 2'(st_valid);
    space = (occ - 2'(pop)) <= 2'd1;
    issue = space && ((state == RS_BYTES) || (state == RS_EMPTY));

    sel_mem  = 1'b0;
    sel_byte = 8'd0;
    priority if (idx < hmfq_pkg::idx_t'(4)) begin
      sel_byte = meta.chan[8*idx[1:0] +: 8];
    end else if (idx == hmfq_pkg::idx_t'(4)) begin
      sel_byte = meta.tag;
    end else if (meta.init && (idx == hmfq_pkg::idx_t'(5))) begin
      sel_byte = meta.len[15:8];
    end else if (meta.init && (idx == hmfq_pkg::idx_t'(6))) begin
      sel_byte = meta.len[7:0];
    end else begin
      sel_mem = hmfq_pkg::fill_t'(idx) < meta.fill;
    end

    rd.meta_en   = do_read;
    rd.meta_slot = head;
    rd.data_en   = issue && (state == RS_BYTES);
    rd.data_addr = hmfq_pkg::byte_addr(rd_slot, idx);

    incoming.frame_byte = st_mem ? data_rdata : st_byte;
    incoming.last       = st_last;
    incoming.empty_res  = st_empty;

    busy = state != RS_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RS_IDLE;
      head  <= '0;
      idx   <= '0;
    end else begin
      unique case (state)
        RS_IDLE: begin
          if (do_clear) begin
            head <= tail;
          end else if (do_read) begin
            if (head == tail) begin
              state <= RS_EMPTY;
            end else begin
              rd_slot <= head;
              head    <= hmfq_pkg::next_slot(head);
              state   <= RS_META;
            end
          end
        end
        RS_META: begin
          meta  <= meta_rdata;
          idx   <= '0;
          state <= RS_BYTES;
        end
        RS_BYTES: begin
          if (issue) begin
            if (idx == hmfq_pkg::idx_t'(hmfq_pkg::FRAME_BYTES - 1)) begin
              state <= RS_IDLE;
            end else begin
              idx <= idx + hmfq_pkg::idx_t'(1);
            end
          end
        end
        RS_EMPTY: begin
          if (issue) begin
            state <= RS_IDLE;
          end
        end
        default: state <= RS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else begin
      st_valid <= issue;
    end
    if (issue) begin
      st_mem   <= (state == RS_BYTES) && sel_mem;
      st_byte  <= (state == RS_BYTES) ? sel_byte : 8'd0;
      st_last  <= (state == RS_EMPTY) ||
                  (idx == hmfq_pkg::idx_t'(hmfq_pkg::FRAME_BYTES - 1));
      st_empty <= state == RS_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!rsp_valid || pop) begin
        if (skid_valid) begin
          rsp       <= skid;
          rsp_valid <= 1'b1;
          if (st_valid) begin
            skid <= incoming;
          end else begin
            skid_valid <= 1'b0;
          end
        end else if (st_valid) begin
          rsp       <= incoming;
          rsp_valid <= 1'b1;
        end else begin
          rsp_valid <= 1'b0;
        end
      end else if (st_valid) begin
        skid       <= incoming;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/hid_message_framer_queue_unit.sv
// Begin, payload and clear transfers may follow back to back. A read of a queued frame
// fetches its header, then issues one byte per cycle while the output can take it;
// header bytes come from the stored header and payload bytes from the payload memory
// port. A read is taken again once all 64 bytes are issued. An empty read gives a single
// result through the issue stage and output register. Reset clears the ring pointers
// and message state at once; the frame store is not cleared and needs no clearing pass.
`default_nettype none
module hid_message_framer_queue_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire hmfq_pkg::req_t  req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output hmfq_pkg::rsp_t       rsp
);

  logic                 accept;
  logic                 do_begin;
  logic                 do_data;
  logic                 do_read;
  logic                 do_clear;
  logic                 busy;
  hmfq_pkg::slot_t      head;
  hmfq_pkg::slot_t      tail;
  hmfq_pkg::data_wr_t   data_wr;
  hmfq_pkg::meta_wr_t   meta_wr;
  hmfq_pkg::rd_req_t    rd;
  logic [7:0]           data_rdata;
  hmfq_pkg::meta_t      meta_rdata;

  always_comb begin
    req_ready = !busy;
    accept    = req_valid && req_ready;
    do_begin  = accept && (req.opcode == hmfq_pkg::OP_BEGIN);
    do_data   = accept && (req.opcode == hmfq_pkg::OP_DATA);
    do_read   = accept && (req.opcode == hmfq_pkg::OP_READ);
    do_clear  = accept && (req.opcode == hmfq_pkg::OP_CLEAR);
  end

  hmfq_builder u_builder (
    .clk      (clk),
    .rst      (rst),
    .do_begin (do_begin),
    .do_data  (do_data),
    .req      (req),
    .head     (head),
    .tail     (tail),
    .data_wr  (data_wr),
    .meta_wr  (meta_wr)
  );

  hmfq_store u_store (
    .clk        (clk),
    .data_wr    (data_wr),
    .meta_wr    (meta_wr),
    .rd         (rd),
    .data_rdata (data_rdata),
    .meta_rdata (meta_rdata)
  );

  hmfq_reader u_reader (
    .clk        (clk),
    .rst        (rst),
    .do_read    (do_read),
    .do_clear   (do_clear),
    .tail       (tail),
    .meta_rdata (meta_rdata),
    .data_rdata (data_rdata),
    .rsp_ready  (rsp_ready),
    .busy       (busy),
    .head       (head),
    .rd         (rd),
    .rsp_valid  (rsp_valid),
    .rsp        (rsp)
  );

endmodule
`default_nettype wire
